[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the default clock and reset of the block.
`define ASSERT_DEF(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hdl/pse_pkg.sv]
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);

  typedef enum logic [3:0] {
    FN_NEG = 4'd0,
    FN_MUL = 4'd1,
    FN_DIV = 4'd2,
    FN_MOD = 4'd3,
    FN_ADD = 4'd4,
    FN_SUB = 4'd5,
    FN_LT  = 4'd6,
    FN_GT  = 4'd7,
    FN_LE  = 4'd8,
    FN_GE  = 4'd9,
    FN_EQ  = 4'd10,
    FN_NE  = 4'd11,
    FN_AND = 4'd12,
    FN_OR  = 4'd13,
    FN_XOR = 4'd14
  } func_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_COUNT = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_OVER  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RD_TOP    = 2'd0,
    RD_SECOND = 2'd1,
    RD_BOTTOM = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    tok_load;
    logic    push;
    logic    set_err;
    status_e err_code;
    rd_sel_e rd_sel;
    logic    load_b;
    logic    load_a;
    logic    div_start;
    logic    wr_result;
    logic    emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       err_none;
    logic       cnt_zero;
    logic       cnt_lt2;
    logic       cnt_full;
    logic       is_op;
    logic [3:0] func;
    logic       last;
    logic       b_zero;
    logic       div_done;
    logic       out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[hdl/pse_divider.sv]
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_divider
  import pse_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o,
  output logic [DATA_W-1:0] remainder_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    quo_q, rem_q, dsr_q;
  logic [DATA_W:0]      rem_shift;
  logic [DATA_W:0]      diff;

  assign rem_shift = {rem_q, quo_q[DATA_W-1]};
  assign diff      = rem_shift - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DATA_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DATA_W-2:0], ~diff[DATA_W]};
      rem_q <= diff[DATA_W] ? rem_shift[DATA_W-1:0] : diff[DATA_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

[hdl/pse_datapath.sv]
// ----------------------------------------------------------------------------
// Postfix evaluator datapath
// Token register, operand stack memory, ALU, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_datapath
  import pse_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DATA_W-1:0] tok_value_i,
  input  logic              tok_is_op_i,
  input  logic [3:0]        tok_func_i,
  input  logic              tok_last_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [DATA_W-1:0] out_value_o,
  output logic [2:0]        out_status_o
);

  // Token register.
  logic              is_op_q, last_q;
  logic [3:0]        func_q;
  logic [DATA_W-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tok_load) begin
      is_op_q <= tok_is_op_i;
      func_q  <= tok_func_i;
      val_q   <= tok_value_i;
      last_q  <= tok_last_i;
    end
  end

  // Stack count and sticky error.
  logic [CNT_W-1:0] cnt_q, cnt_d;
  status_e          err_q, err_d;
  logic [CNT_W-1:0] cnt_m1, cnt_m2;
  logic [PTR_W-1:0] top_idx, second_idx;

  assign cnt_m1     = cnt_q - CNT_W'(1);
  assign cnt_m2     = cnt_q - CNT_W'(2);
  assign top_idx    = cnt_m1[PTR_W-1:0];
  assign second_idx = cnt_m2[PTR_W-1:0];

  always_comb begin
    cnt_d = cnt_q;
    err_d = err_q;
    if (cmd_i.emit) begin
      cnt_d = '0;
      err_d = ST_OK;
    end else begin
      if (cmd_i.push) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else if (cmd_i.wr_result && (func_q != FN_NEG)) begin
        cnt_d = cnt_m1;
      end
      if (cmd_i.set_err) begin
        err_d = cmd_i.err_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      err_q <= ST_OK;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
    end
  end

  // Operand stack memory, one write and one registered read per cycle.
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [PTR_W-1:0]  rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_TOP:    rd_addr = top_idx;
      RD_SECOND: rd_addr = second_idx;
      RD_BOTTOM: rd_addr = '0;
      default:   rd_addr = top_idx;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rdata_q <= stack_mem[rd_addr];
  end

  // Operand registers.
  logic [DATA_W-1:0] a_q, b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_b) begin
      b_q <= rdata_q;
    end
    if (cmd_i.load_a) begin
      a_q <= rdata_q;
    end
  end

  // ALU for everything but division and modulo.
  logic [DATA_W-1:0] alu_res;

  always_comb begin
    unique case (func_q)
      FN_NEG:  alu_res = '0 - b_q;
      FN_MUL:  alu_res = a_q * b_q;
      FN_ADD:  alu_res = a_q + b_q;
      FN_SUB:  alu_res = a_q - b_q;
      FN_LT:   alu_res = DATA_W'($signed(a_q) < $signed(b_q));
      FN_GT:   alu_res = DATA_W'($signed(b_q) < $signed(a_q));
      FN_LE:   alu_res = DATA_W'(!($signed(b_q) < $signed(a_q)));
      FN_GE:   alu_res = DATA_W'(!($signed(a_q) < $signed(b_q)));
      FN_EQ:   alu_res = DATA_W'(a_q == b_q);
      FN_NE:   alu_res = DATA_W'(a_q != b_q);
      FN_AND:  alu_res = DATA_W'((a_q != '0) && (b_q != '0));
      FN_OR:   alu_res = DATA_W'((a_q != '0) || (b_q != '0));
      default: alu_res = a_q ^ b_q;
    endcase
  end

  // Division works on magnitudes; signs are restored afterwards.
  logic [DATA_W-1:0] mag_a, mag_b, quo, rem, div_res;
  logic              div_done;

  assign mag_a = a_q[DATA_W-1] ? ('0 - a_q) : a_q;
  assign mag_b = b_q[DATA_W-1] ? ('0 - b_q) : b_q;

  pse_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (mag_a),
    .divisor_i   (mag_b),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  always_comb begin
    if (func_q == FN_DIV) begin
      div_res = (a_q[DATA_W-1] ^ b_q[DATA_W-1]) ? ('0 - quo) : quo;
    end else begin
      div_res = a_q[DATA_W-1] ? ('0 - rem) : rem;
    end
  end

  // Stack write port.
  logic is_div;

  assign is_div  = (func_q == FN_DIV) || (func_q == FN_MOD);
  assign wr_en   = cmd_i.push || cmd_i.wr_result;

  always_comb begin
    if (cmd_i.push) begin
      wr_addr = cnt_q[PTR_W-1:0];
      wr_data = val_q;
    end else begin
      wr_addr = (func_q == FN_NEG) ? top_idx : second_idx;
      wr_data = is_div ? div_res : alu_res;
    end
  end

  // Result register; it frees up on the same cycle the beat is taken.
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q;
  status_e           out_status_q;
  status_e           fin_status;

  always_comb begin
    if (err_q != ST_OK) begin
      fin_status = err_q;
    end else if (cnt_q != CNT_W'(1)) begin
      fin_status = ST_COUNT;
    end else begin
      fin_status = ST_OK;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= fin_status;
      out_value_q  <= (fin_status == ST_OK) ? rdata_q : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

  always_comb begin
    sts_o.err_none = (err_q == ST_OK);
    sts_o.cnt_zero = (cnt_q == '0);
    sts_o.cnt_lt2  = (cnt_q < CNT_W'(2));
    sts_o.cnt_full = (cnt_q >= CNT_W'(STACK_DEPTH));
    sts_o.is_op    = is_op_q;
    sts_o.func     = func_q;
    sts_o.last     = last_q;
    sts_o.b_zero   = (b_q == '0);
    sts_o.div_done = div_done;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

[hdl/pse_controller.sv]
// ----------------------------------------------------------------------------
// Postfix evaluator controller
// Sequences one token at a time through decode, operand fetch and execute.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_controller
  import pse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_LOAD_B   = 8'b0000_0100,
    S_LOAD_A   = 8'b0000_1000,
    S_ALU      = 8'b0001_0000,
    S_DIV_WAIT = 8'b0010_0000,
    S_END_TOK  = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   is_div;

  assign is_div = (sts_i.func == FN_DIV) || (sts_i.func == FN_MOD);

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.err_code = ST_OK;
    cmd_o.rd_sel   = RD_TOP;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.tok_load = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_END_TOK;
        if (!sts_i.err_none) begin
          state_d = S_END_TOK;
        end else if (!sts_i.is_op) begin
          if (sts_i.cnt_full) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = ST_OVER;
          end else begin
            cmd_o.push = 1'b1;
          end
        end else if (sts_i.func > FN_XOR) begin
          state_d = S_END_TOK;
        end else if (sts_i.func == FN_NEG) begin
          if (sts_i.cnt_zero) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = ST_FEW;
          end else begin
            state_d = S_LOAD_B;
          end
        end else if (sts_i.cnt_lt2) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = ST_FEW;
        end else begin
          state_d = S_LOAD_B;
        end
      end

      S_LOAD_B: begin
        cmd_o.load_b = 1'b1;
        cmd_o.rd_sel = RD_SECOND;
        state_d      = (sts_i.func == FN_NEG) ? S_ALU : S_LOAD_A;
      end

      S_LOAD_A: begin
        cmd_o.load_a = 1'b1;
        state_d      = S_ALU;
      end

      S_ALU: begin
        if (is_div) begin
          if (sts_i.b_zero) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = ST_DIVZ;
            state_d        = S_END_TOK;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV_WAIT;
          end
        end else begin
          cmd_o.wr_result = 1'b1;
          state_d         = S_END_TOK;
        end
      end

      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.wr_result = 1'b1;
          state_d         = S_END_TOK;
        end
      end

      S_END_TOK: begin
        cmd_o.rd_sel = RD_BOTTOM;
        state_d      = sts_i.last ? S_EMIT : S_IDLE;
      end

      S_EMIT: begin
        cmd_o.rd_sel = RD_BOTTOM;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hdl/postfix_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// Postfix stack evaluator
// Evaluates a reverse Polish integer expression streamed in one token a beat.
// ----------------------------------------------------------------------------
// Tokens arrive on the slave stream, one per beat, and are processed one at a
// time: an operand is pushed in the decode state, negation fetches one operand,
// the binary operators fetch two, and division or modulo then wait on
// the bit-serial divider, which produces one quotient bit per cycle.
// A token with tlast set then loads the result register and emits one result
// beat holding the final value and a status code. The operand stack is a
// 16-entry memory with a single registered read port, so each operand of an
// operator is fetched in a cycle of its own. The result register decouples
// the master side: new tokens are taken while a result beat still waits, and
// only the next tlast token waits for it to drain. After any error the rest
// of the expression is skipped and the tlast token reports the first error
// seen; the block then starts clean.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module postfix_stack_evaluator
  import pse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Token stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] operand_value
  input  logic [4:0]  s_axis_tuser_i,   // [0] is_operator, [4:1] func
  input  logic        s_axis_tlast_i,   // last
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] result_value
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // The controller owns sequencing; the datapath holds every stored value.
  pse_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pse_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_value_i  (s_axis_tdata_i),
    .tok_is_op_i  (s_axis_tuser_i[0]),
    .tok_func_i   (s_axis_tuser_i[4:1]),
    .tok_last_i   (s_axis_tlast_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_value_o  (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

  // Once a token beat is taken, tready drops while the sequencer works on it.
  `ASSERT_DEF(a_one_token_at_a_time, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o, "token accepted while busy")
  // A result beat only appears after the controller asked for it.
  `ASSERT_DEF(a_result_from_emit, $rose(m_axis_tvalid_o) |-> $past(cmd.emit), "result beat without emit")
  // The divider is never started on a zero divisor.
  `ASSERT_DEF(a_no_zero_divide, cmd.div_start |-> !sts.b_zero, "divider started with zero divisor")
  // Any error status carries a zero value.
  `ASSERT_DEF(a_error_value_zero, (m_axis_tvalid_o && (m_axis_tuser_o != ST_OK)) |-> (m_axis_tdata_o == '0), "nonzero value with error status")

endmodule

`default_nettype wire
